[src/ladder_encoder_event_decoder_defines.svh]
// Assertion macros for the ladder encoder event decoder, used by leed_track.
// Needs a clk and an arst_n signal in the module that uses them.
`ifndef LADDER_ENCODER_EVENT_DECODER_DEFINES_SVH
`define LADDER_ENCODER_EVENT_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEED_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/leed_pkg.sv]
// Package for the ladder encoder event decoder: codes, reset values and the
// control struct passed from the top level to the tracker. No dependencies.
package leed_pkg;

	localparam int unsigned ADC_W = 10;

	localparam logic [1:0] REG_LEVEL_ONE   = 2'd0;
	localparam logic [1:0] REG_LEVEL_TWO   = 2'd1;
	localparam logic [1:0] REG_LEVEL_THREE = 2'd2;

	localparam logic [ADC_W-1:0] LEVEL_ONE_RESET   = 10'd320;
	localparam logic [ADC_W-1:0] LEVEL_TWO_RESET   = 10'd400;
	localparam logic [ADC_W-1:0] LEVEL_THREE_RESET = 10'd1000;

	localparam logic [1:0] LVL_IDLE  = 2'd0;
	localparam logic [1:0] LVL_ONE   = 2'd1;
	localparam logic [1:0] LVL_TWO   = 2'd2;
	localparam logic [1:0] LVL_THREE = 2'd3;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_PRESS = 2'd1;
	localparam logic [1:0] EV_PLUS  = 2'd2;
	localparam logic [1:0] EV_MINUS = 2'd3;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Rotation progress, two's complement.
	localparam logic [2:0] PROG_ZERO   = 3'b000;
	localparam logic [2:0] PROG_PLUS1  = 3'b001;
	localparam logic [2:0] PROG_PLUS2  = 3'b010;
	localparam logic [2:0] PROG_MINUS1 = 3'b111;
	localparam logic [2:0] PROG_MINUS2 = 3'b110;

	typedef struct packed {
		logic       fire;
		logic       op;
		logic       button_level;
		logic [1:0] level;
	} trk_ctl_t;

endpackage

[src/leed_level.sv]
// Ladder level classifier: sorts an ADC reading against three limits.
// Depends on leed_pkg.
module leed_level import leed_pkg::*; (
	input  logic [ADC_W-1:0] adc_sample,
	input  logic [ADC_W-1:0] level_one_limit,
	input  logic [ADC_W-1:0] level_two_limit,
	input  logic [ADC_W-1:0] level_three_limit,
	output logic [1:0]       level
);

	always_comb begin
		priority if (adc_sample < level_one_limit) begin
			level = LVL_ONE;
		end else if (adc_sample < level_two_limit) begin
			level = LVL_TWO;
		end else if (adc_sample < level_three_limit) begin
			level = LVL_THREE;
		end else begin
			level = LVL_IDLE;
		end
	end

endmodule

[src/leed_track.sv]
// Rotation and button tracker: holds the decoder state and forms the event
// code for each word. Depends on leed_pkg and the assertion macro header.
`include "ladder_encoder_event_decoder_defines.svh"

module leed_track import leed_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  trk_ctl_t ctl,
	output logic [1:0] event_code
);

	logic [2:0] progress_q;
	logic [1:0] prev_level_q;
	logic       held_q;
	logic [1:0] pend_q;

	logic [2:0] progress_d;
	logic [1:0] prev_level_d;
	logic       held_d;
	logic [1:0] pend_d;

	always_comb begin
		progress_d   = progress_q;
		prev_level_d = prev_level_q;
		held_d       = held_q;
		pend_d       = pend_q;
		event_code   = EV_NONE;
		if (ctl.op == OP_READ) begin
			event_code = pend_q;
			pend_d     = EV_NONE;
		end else begin
			if (!ctl.button_level && !held_q) begin
				pend_d = EV_PRESS;
				held_d = 1'b1;
			end else if (ctl.button_level && held_q) begin
				held_d = 1'b0;
			end
			if (ctl.level != LVL_IDLE && ctl.level != prev_level_q) begin
				prev_level_d = ctl.level;
				priority if (ctl.level == LVL_TWO && progress_q == PROG_ZERO) begin
					progress_d = PROG_PLUS1;
				end else if (ctl.level == LVL_THREE && progress_q == PROG_ZERO) begin
					progress_d = PROG_MINUS1;
				end else if (ctl.level == LVL_ONE && progress_q == PROG_PLUS1) begin
					progress_d = PROG_PLUS2;
				end else if (ctl.level == LVL_ONE && progress_q == PROG_MINUS1) begin
					progress_d = PROG_MINUS2;
				end else if (ctl.level == LVL_THREE && progress_q == PROG_PLUS2) begin
					pend_d     = EV_PLUS;
					progress_d = PROG_ZERO;
				end else if (ctl.level == LVL_TWO && progress_q == PROG_MINUS2) begin
					pend_d     = EV_MINUS;
					progress_d = PROG_ZERO;
				end else begin
					progress_d = PROG_ZERO;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q   <= PROG_ZERO;
			prev_level_q <= LVL_IDLE;
			held_q       <= 1'b0;
			pend_q       <= EV_NONE;
		end else if (ctl.fire) begin
			progress_q   <= progress_d;
			prev_level_q <= prev_level_d;
			held_q       <= held_d;
			pend_q       <= pend_d;
		end
	end

	`LEED_ASSERT_NOW(a_progress_range, 1'b1, progress_q != 3'b011 && progress_q != 3'b100 && progress_q != 3'b101, "rotation progress left the range -2 to 2")
	`LEED_ASSERT_NEXT(a_read_clears, ctl.fire && ctl.op == OP_READ, pend_q == EV_NONE, "pending event not cleared by a read")
	`LEED_ASSERT_NEXT(a_press_latched, ctl.fire && ctl.op == OP_SAMPLE && !ctl.button_level && !held_q, pend_q != EV_NONE && held_q, "button press not latched")
	`LEED_ASSERT_NEXT(a_idle_holds, !ctl.fire, $stable(progress_q) && $stable(pend_q) && $stable(prev_level_q), "tracker state changed without a word")

endmodule

[src/ladder_encoder_event_decoder.sv]
// Top level of the ladder encoder event decoder: input and result registers,
// limit registers and handshake. Depends on leed_pkg, leed_level, leed_track.
//
//  Channel | Signals                                   | Direction
//  in      | in_valid, in_stall, op, adc_sample,       | word in
//          | button_level                              |
//  out     | out_valid, out_stall, event_code          | word out
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// A word waits in the input register and is decoded into the result register once that
// register is free, so a word is taken in every cycle while the output is not stalled. The
// level compare and state update between the two registers are combinational.
// Reset clears the decoder state and loads the default limits.
// A stalled result holds the input register; the input stalls only while
// both registers are full and the output is stalled.
module ladder_encoder_event_decoder import leed_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             op,
	input  logic [ADC_W-1:0] adc_sample,
	input  logic             button_level,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       event_code,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [ADC_W-1:0] cfg_data
);

	logic [ADC_W-1:0] level_one_q;
	logic [ADC_W-1:0] level_two_q;
	logic [ADC_W-1:0] level_three_q;

	logic             valid_s1;
	logic             op_s1;
	logic [ADC_W-1:0] adc_s1;
	logic             button_s1;

	logic             out_valid_q;
	logic [1:0]       event_q;

	logic       advance;
	logic       accept;
	logic [1:0] level;
	logic [1:0] event_d;
	trk_ctl_t   ctl;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_one_q   <= LEVEL_ONE_RESET;
			level_two_q   <= LEVEL_TWO_RESET;
			level_three_q <= LEVEL_THREE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_LEVEL_ONE) begin
				level_one_q <= cfg_data;
			end
			if (cfg_index == REG_LEVEL_TWO) begin
				level_two_q <= cfg_data;
			end
			if (cfg_index == REG_LEVEL_THREE) begin
				level_three_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			adc_s1    <= adc_sample;
			button_s1 <= button_level;
		end
		if (advance) begin
			event_q <= event_d;
		end
	end

	leed_level u_level (
		.adc_sample        (adc_s1),
		.level_one_limit   (level_one_q),
		.level_two_limit   (level_two_q),
		.level_three_limit (level_three_q),
		.level             (level)
	);

	always_comb begin
		ctl.fire         = advance;
		ctl.op           = op_s1;
		ctl.button_level = button_s1;
		ctl.level        = level;
	end

	leed_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.event_code (event_d)
	);

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench for the ladder encoder event decoder: directed table, then random phases under
// several limit settings, each result checked against a typed code or a local predictor.
// Depends on leed_pkg and ladder_encoder_event_decoder.
module testbench import leed_pkg::*; ();

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 80;

	typedef struct packed {
		logic             op;
		logic [ADC_W-1:0] adc;
		logic             btn;
		logic             typed;
		logic [1:0]       code;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             op;
	logic [ADC_W-1:0] adc_sample;
	logic             button_level;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       event_code;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [ADC_W-1:0] cfg_data;

	logic [ADC_W-1:0] lim_one;
	logic [ADC_W-1:0] lim_two;
	logic [ADC_W-1:0] lim_three;
	logic [2:0]       progress;
	logic [1:0]       last_level;
	logic             button_down;
	logic [1:0]       latched_event;

	logic [1:0] expected_codes [$];
	logic [1:0] want;
	int         mismatches;
	int         words_sent;
	int         cycle_count;
	bit         quiet;
	bit         hold_request;

	stim_row_t directed_rows [0:25] = '{
		'{OP_READ,   10'd0,    1'b1, 1'b1, EV_NONE},
		'{OP_SAMPLE, 10'd350,  1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd0,    1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd999,  1'b1, 1'b0, EV_NONE},
		'{OP_READ,   10'd1023, 1'b0, 1'b1, EV_PLUS},
		'{OP_SAMPLE, 10'd1000, 1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd319,  1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd500,  1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd1000, 1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd319,  1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd319,  1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd320,  1'b1, 1'b0, EV_NONE},
		'{OP_READ,   10'd0,    1'b1, 1'b1, EV_MINUS},
		'{OP_SAMPLE, 10'd1023, 1'b0, 1'b0, EV_NONE},
		'{OP_READ,   10'd0,    1'b1, 1'b1, EV_PRESS},
		'{OP_SAMPLE, 10'd1023, 1'b0, 1'b0, EV_NONE},
		'{OP_READ,   10'd0,    1'b1, 1'b1, EV_NONE},
		'{OP_SAMPLE, 10'd1023, 1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd0,    1'b0, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd350,  1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd0,    1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd500,  1'b0, 1'b0, EV_NONE},
		'{OP_READ,   10'd0,    1'b1, 1'b1, EV_PLUS},
		'{OP_SAMPLE, 10'd350,  1'b1, 1'b0, EV_NONE},
		'{OP_SAMPLE, 10'd500,  1'b1, 1'b0, EV_NONE},
		'{OP_READ,   10'd0,    1'b1, 1'b1, EV_NONE}
	};

	ladder_encoder_event_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.adc_sample   (adc_sample),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_code   (event_code),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [1:0] level_of(input logic [ADC_W-1:0] a);
		if (a < lim_one)
			return LVL_ONE;
		if (a < lim_two)
			return LVL_TWO;
		if (a < lim_three)
			return LVL_THREE;
		return LVL_IDLE;
	endfunction

	// Works out the event code for one word and advances the decoder state.
	task automatic decode_word(input logic o, input logic [ADC_W-1:0] a, input logic b,
			output logic [1:0] code);
		logic [1:0] lvl;
		code = EV_NONE;
		if (o == OP_READ) begin
			code = latched_event;
			latched_event = EV_NONE;
		end else begin
			if (!b && !button_down) begin
				latched_event = EV_PRESS;
				button_down = 1'b1;
			end else if (b && button_down) begin
				button_down = 1'b0;
			end
			lvl = level_of(a);
			if (lvl != LVL_IDLE && lvl != last_level) begin
				if (lvl == LVL_TWO && progress == PROG_ZERO)
					progress = PROG_PLUS1;
				else if (lvl == LVL_THREE && progress == PROG_ZERO)
					progress = PROG_MINUS1;
				else if (lvl == LVL_ONE && progress == PROG_PLUS1)
					progress = PROG_PLUS2;
				else if (lvl == LVL_ONE && progress == PROG_MINUS1)
					progress = PROG_MINUS2;
				else if (lvl == LVL_THREE && progress == PROG_PLUS2) begin
					latched_event = EV_PLUS;
					progress = PROG_ZERO;
				end else if (lvl == LVL_TWO && progress == PROG_MINUS2) begin
					latched_event = EV_MINUS;
					progress = PROG_ZERO;
				end else
					progress = PROG_ZERO;
				last_level = lvl;
			end
		end
	endtask

	task automatic note_mismatch(input string msg);
		if (mismatches < 40)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// Offers one word, waits for it to be taken, records what it should return, then
	// perhaps leaves a gap.
	task automatic send_word(input logic o, input logic [ADC_W-1:0] a, input logic b,
			input logic typed, input logic [1:0] typed_code);
		logic [1:0] code;
		in_valid     <= 1'b1;
		op           <= o;
		adc_sample   <= a;
		button_level <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decode_word(o, a, b, code);
		expected_codes.push_back(typed ? typed_code : code);
		words_sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
		end
	endtask

	function automatic logic [ADC_W-1:0] pick_adc(input logic [1:0] lvl);
		logic [ADC_W-1:0] a;
		int n;
		a = 10'($urandom_range(0, 1023));
		for (n = 0; n < 48; n++) begin
			case ($urandom_range(0, 5))
				0: a = lim_one - 10'($urandom_range(0, 1));
				1: a = lim_two - 10'($urandom_range(0, 1));
				2: a = lim_three - 10'($urandom_range(0, 1));
				default: a = 10'($urandom_range(0, 1023));
			endcase
			if (level_of(a) == lvl)
				return a;
		end
		return a;
	endfunction

	function automatic logic pick_button();
		return ($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
	endfunction

	task automatic send_rotation();
		logic [1:0] seq [0:2];
		logic       plus;
		logic [1:0] lvl;
		int k;
		plus = 1'($urandom_range(0, 1));
		seq[0] = plus ? LVL_TWO : LVL_THREE;
		seq[1] = LVL_ONE;
		seq[2] = plus ? LVL_THREE : LVL_TWO;
		// Level one first, so the next two levels of the sequence are new unless a random level replaces one.
		send_word(OP_SAMPLE, pick_adc(LVL_ONE), pick_button(), 1'b0, EV_NONE);
		for (k = 0; k < 3; k++) begin
			lvl = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) : seq[k];
			send_word(OP_SAMPLE, pick_adc(lvl), pick_button(), 1'b0, EV_NONE);
			if ($urandom_range(0, 3) == 0)
				send_word(OP_SAMPLE, pick_adc($urandom_range(0, 1) ? LVL_IDLE : lvl),
					pick_button(), 1'b0, EV_NONE);
			if ($urandom_range(0, 9) == 0)
				send_word(OP_READ, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
					1'b0, EV_NONE);
		end
		if ($urandom_range(0, 2) != 0)
			send_word(OP_READ, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 1'b0,
				EV_NONE);
	endtask

	task automatic send_noise();
		int k;
		for (k = $urandom_range(1, 4); k > 0; k--)
			send_word(($urandom_range(0, 3) == 0) ? OP_READ : OP_SAMPLE,
				10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 1'b0, EV_NONE);
	endtask

	task automatic send_button();
		int k;
		for (k = $urandom_range(1, 3); k > 0; k--)
			send_word(OP_SAMPLE, 10'($urandom_range(0, 1023)), 1'b0, 1'b0, EV_NONE);
		send_word(OP_SAMPLE, 10'($urandom_range(0, 1023)), 1'b1, 1'b0, EV_NONE);
		send_word(OP_READ, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 1'b0,
			EV_NONE);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limits(input logic [ADC_W-1:0] l1, input logic [ADC_W-1:0] l2,
			input logic [ADC_W-1:0] l3);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LEVEL_ONE;
		cfg_data  <= l1;
		@(posedge clk);
		cfg_index <= REG_LEVEL_TWO;
		cfg_data  <= l2;
		@(posedge clk);
		cfg_index <= REG_LEVEL_THREE;
		cfg_data  <= l3;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lim_one   = l1;
		lim_two   = l2;
		lim_three = l3;
	endtask

	task automatic run_phase(input logic [ADC_W-1:0] l1, input logic [ADC_W-1:0] l2,
			input logic [ADC_W-1:0] l3, input int count, input bit do_hold,
			input bit do_pause, input bit is_quiet);
		int target;
		bit paused;
		bit hold_done;
		wait_drained();
		write_limits(l1, l2, l3);
		quiet     = is_quiet;
		target    = words_sent + count;
		paused    = 1'b0;
		hold_done = 1'b0;
		while (words_sent < target) begin
			if (do_hold && !hold_done && words_sent + count - target >= 20) begin
				hold_request = 1'b1;
				hold_done    = 1'b1;
			end
			if (do_pause && !paused && target - words_sent < count / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: send_rotation();
				6, 7: send_noise();
				default: send_button();
			endcase
		end
	endtask

	initial begin
		int i;
		logic [ADC_W-1:0] r1;
		logic [ADC_W-1:0] r2;
		logic [ADC_W-1:0] r3;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		op            <= OP_SAMPLE;
		adc_sample    <= '0;
		button_level  <= 1'b1;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_LEVEL_ONE;
		cfg_data      <= '0;
		lim_one       = LEVEL_ONE_RESET;
		lim_two       = LEVEL_TWO_RESET;
		lim_three     = LEVEL_THREE_RESET;
		progress      = PROG_ZERO;
		last_level    = LVL_IDLE;
		button_down   = 1'b0;
		latched_event = EV_NONE;
		mismatches    = 0;
		words_sent    = 0;
		quiet         = 1'b0;
		hold_request  = 1'b0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 26; i++)
			send_word(directed_rows[i].op, directed_rows[i].adc, directed_rows[i].btn,
				directed_rows[i].typed, directed_rows[i].code);

		run_phase(10'd320, 10'd400, 10'd1000, 300, 1'b1, 1'b0, 1'b0);
		run_phase(10'd0, 10'd0, 10'd0, 120, 1'b0, 1'b0, 1'b0);
		run_phase(10'd1023, 10'd1023, 10'd1023, 150, 1'b0, 1'b0, 1'b0);
		run_phase(10'd800, 10'd200, 10'd900, 250, 1'b0, 1'b1, 1'b0);
		r1 = 10'($urandom_range(0, 1023));
		r2 = 10'($urandom_range(0, 1023));
		r3 = 10'($urandom_range(0, 1023));
		run_phase(r1, r2, r3, 250, 1'b0, 1'b0, 1'b0);
		r1 = 10'($urandom_range(1, 340));
		r2 = r1 + 10'($urandom_range(1, 340));
		r3 = r2 + 10'($urandom_range(1, 340));
		run_phase(r1, r2, r3, 300, 1'b0, 1'b0, 1'b0);
		run_phase(10'd320, 10'd400, 10'd1000, 300, 1'b0, 1'b0, 1'b1);

		wait_drained();
		repeat (8)
			@(posedge clk);
		if (mismatches == 0 && expected_codes.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// The receiver stalls in random bursts outside the quiet phase; once it holds off long
	// enough for the block to fill up and stall its input.
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD)
					@(posedge clk);
			end else if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12))
					@(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12))
					@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_codes.size() == 0)
				note_mismatch($sformatf("word out with nothing expected, event_code %0d",
					event_code));
			else begin
				want = expected_codes.pop_front();
				if (event_code !== want)
					note_mismatch($sformatf("event_code %0d, expected %0d", event_code,
						want));
			end
		end
	end

	initial
		cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule
